/* design/imu_bfc_pkg.sv */
// ----------------------------------------------------------------------------
// IMU burst frame checker package
// Shared frame layout constants and the beat and result types.
// ----------------------------------------------------------------------------
`default_nettype none

package imu_bfc_pkg;

    // Frame layout.
    localparam int FRAME_LENGTH  = 20;
    localparam int SUM_BYTES     = 18;
    localparam int CHK_HIGH_POS  = 18;
    localparam int CHK_LOW_POS   = 19;
    localparam int NUM_MOTION    = 6;
    localparam int MOTION_BASE   = 2;
    localparam int TEMP_BASE     = 14;
    localparam int DIAG_BASE     = 0;
    localparam int COUNT_BASE    = 16;

    // Byte position counter; the value FRAME_LENGTH means the frame is done.
    localparam int POS_W         = $clog2(FRAME_LENGTH + 1);
    localparam int STORE_IDX_W   = $clog2(SUM_BYTES);

    // Temperature conversion: raw * 5 + 2500 in hundredths of a degree.
    localparam int TEMP_W        = 19;
    localparam int TEMP_OFFSET   = 2500;

    // Output beat width, padded to whole bytes.
    localparam int RESULT_BITS   = 6 * 16 + TEMP_W + 16 + 16;
    localparam int OUT_TDATA_W   = ((RESULT_BITS + 7) / 8) * 8;

    typedef logic [POS_W-1:0] t_pos;

    // One input beat.
    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_start;
    } t_in_beat;

    // One result.
    typedef struct packed {
        logic signed [15:0]       gyro_x;
        logic signed [15:0]       gyro_y;
        logic signed [15:0]       gyro_z;
        logic signed [15:0]       accel_x;
        logic signed [15:0]       accel_y;
        logic signed [15:0]       accel_z;
        logic signed [TEMP_W-1:0] temperature_centi;
        logic        [15:0]       diag_status;
        logic        [15:0]       sample_count;
        logic                     checksum_ok;
    } t_result;

endpackage

`default_nettype wire

/* design/imu_bfc_in_reg.sv */
// ----------------------------------------------------------------------------
// IMU burst frame checker input register
// Captures one byte beat from the input stream per cycle while s_axis_tready is high.
// ----------------------------------------------------------------------------
`default_nettype none

module imu_bfc_in_reg
    import imu_bfc_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     s_axis_tvalid,
    output logic          s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] frame_byte
    input  wire logic     s_axis_tuser,     // [0] frame_start
    input  wire logic     i_advance,
    output logic          o_beat_valid,
    output t_in_beat      o_beat
);

    logic     r_valid;
    t_in_beat r_beat;

    // The register can take a beat when empty or when its content moves on.
    assign s_axis_tready = !r_valid || i_advance;

    // Valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_valid <= s_axis_tvalid;
        end
    end

    // Beat payload.
    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_beat.frame_byte  <= s_axis_tdata;
            r_beat.frame_start <= s_axis_tuser;
        end
    end

    assign o_beat_valid = r_valid;
    assign o_beat       = r_beat;

endmodule

`default_nettype wire

/* design/imu_bfc_core.sv */
// ----------------------------------------------------------------------------
// IMU burst frame checker core
// Tracks the frame position, stores bytes, sums them and builds the result.
// ----------------------------------------------------------------------------
`default_nettype none

module imu_bfc_core
    import imu_bfc_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_beat_valid,
    input  wire t_in_beat i_beat,
    input  wire logic     i_out_free,
    output logic          o_advance,
    output logic          o_result_valid,
    output t_result       o_result
);

    t_pos        r_pos;
    logic [15:0] r_sum;
    logic [7:0]  r_chk_hi;
    logic [7:0]  r_store [SUM_BYTES];
    logic [15:0] r_good  [NUM_MOTION];

    t_pos        pos;
    logic [15:0] sum_base;
    logic        in_frame;
    logic        is_store;
    logic        is_chk_hi;
    logic        is_last;
    logic        ok;
    logic [15:0] motion_new [NUM_MOTION];
    logic [15:0] motion_out [NUM_MOTION];
    logic signed [TEMP_W-1:0] temp_raw;
    logic signed [TEMP_W-1:0] temp_centi;

    // A start flag restarts the frame before this byte is placed.
    assign pos       = i_beat.frame_start ? '0 : r_pos;
    assign sum_base  = i_beat.frame_start ? '0 : r_sum;
    assign in_frame  = pos < t_pos'(FRAME_LENGTH);
    assign is_store  = pos < t_pos'(SUM_BYTES);
    assign is_chk_hi = pos == t_pos'(CHK_HIGH_POS);
    assign is_last   = pos == t_pos'(CHK_LOW_POS);

    // Only a beat that completes a frame needs room in the output register.
    assign o_advance      = i_beat_valid && (!is_last || i_out_free);
    assign o_result_valid = o_advance && is_last;

    // Checksum compare against the big-endian word in the last two bytes.
    assign ok = {r_chk_hi, i_beat.frame_byte} == r_sum;

    // Motion words from this frame, and the words that go out.
    always_comb begin
        for (int k = 0; k < NUM_MOTION; k++) begin
            motion_new[k] = {r_store[MOTION_BASE + 2*k], r_store[MOTION_BASE + 2*k + 1]};
            motion_out[k] = ok ? motion_new[k] : r_good[k];
        end
    end

    // Temperature: raw * 5 + 2500, exact in 19 bits.
    assign temp_raw   = TEMP_W'($signed({r_store[TEMP_BASE], r_store[TEMP_BASE + 1]}));
    assign temp_centi = (temp_raw <<< 2) + temp_raw + TEMP_W'(TEMP_OFFSET);

    // Result record.
    always_comb begin
        o_result.gyro_x            = motion_out[0];
        o_result.gyro_y            = motion_out[1];
        o_result.gyro_z            = motion_out[2];
        o_result.accel_x           = motion_out[3];
        o_result.accel_y           = motion_out[4];
        o_result.accel_z           = motion_out[5];
        o_result.temperature_centi = temp_centi;
        o_result.diag_status       = {r_store[DIAG_BASE], r_store[DIAG_BASE + 1]};
        o_result.sample_count      = {r_store[COUNT_BASE], r_store[COUNT_BASE + 1]};
        o_result.checksum_ok       = ok;
    end

    // Frame position, running sum, checksum high byte and held motion words.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_sum    <= '0;
            r_chk_hi <= '0;
            for (int k = 0; k < NUM_MOTION; k++) begin
                r_good[k] <= '0;
            end
        end else if (o_advance) begin
            if (i_beat.frame_start) begin
                r_pos <= '0;
                r_sum <= '0;
            end
            if (in_frame) begin
                r_pos <= pos + t_pos'(1);
            end
            if (is_store) begin
                r_sum <= sum_base + {8'd0, i_beat.frame_byte};
            end
            if (is_chk_hi) begin
                r_chk_hi <= i_beat.frame_byte;
            end
            if (is_last && ok) begin
                for (int k = 0; k < NUM_MOTION; k++) begin
                    r_good[k] <= motion_new[k];
                end
            end
        end
    end

    // Frame byte store; every entry is written before it is read in a frame.
    always_ff @(posedge i_clk) begin
        if (o_advance && is_store) begin
            for (int i = 0; i < SUM_BYTES; i++) begin
                if (pos[STORE_IDX_W-1:0] == STORE_IDX_W'(i)) begin
                    r_store[i] <= i_beat.frame_byte;
                end
            end
        end
    end

endmodule

`default_nettype wire

/* design/imu_bfc_out_reg.sv */
// ----------------------------------------------------------------------------
// IMU burst frame checker output register
// Holds one result beat until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module imu_bfc_out_reg
    import imu_bfc_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_load,
    input  wire t_result  i_result,
    output logic          o_free,
    output logic          m_axis_tvalid,
    input  wire logic     m_axis_tready,
    // [15:0] gyro_x, [31:16] gyro_y, [47:32] gyro_z, [63:48] accel_x,
    // [79:64] accel_y, [95:80] accel_z, [114:96] temperature_centi,
    // [130:115] diag_status, [146:131] sample_count, [151:147] zero
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    output logic          m_axis_tuser      // [0] checksum_ok
);

    logic    r_valid;
    t_result r_result;

    // Free when empty or when the held beat is taken this cycle.
    assign o_free = !r_valid || m_axis_tready;

    // Valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_valid <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = {(OUT_TDATA_W - RESULT_BITS)'(0),
                            r_result.sample_count,
                            r_result.diag_status,
                            r_result.temperature_centi,
                            r_result.accel_z,
                            r_result.accel_y,
                            r_result.accel_x,
                            r_result.gyro_z,
                            r_result.gyro_y,
                            r_result.gyro_x};
    assign m_axis_tuser  = r_result.checksum_ok;

endmodule

`default_nettype wire

/* design/imu_burst_frame_checker.sv */
// ----------------------------------------------------------------------------
// IMU burst frame checker
// Checks 20-byte inertial sensor burst frames and reports decoded words.
// ----------------------------------------------------------------------------
// The block takes one frame byte per beat and accepts a beat in every cycle
// except while its input side stalls. A beat with tuser set starts a new
// frame; after reset the first byte is taken as byte 0 even without it.
// Bytes 0-17 are summed into a wrapping 16-bit sum and checked against the
// big-endian word in bytes 18-19. One result beat follows each completed
// frame: byte 19 is first captured in the input register, and the result
// register loads from it once the output register is free. Gyro and accel
// words are updated only on a passing frame and otherwise hold the last good
// values; temperature, status and counter come from the current frame. Bytes
// after the 20th are dropped until the next start. The input side stalls
// only while a finished result waits in the output register and the next
// byte would complete another frame.
// ----------------------------------------------------------------------------
`default_nettype none

module imu_burst_frame_checker
    import imu_bfc_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     s_axis_tvalid,
    output logic          s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] frame_byte
    input  wire logic     s_axis_tuser,     // [0] frame_start
    output logic          m_axis_tvalid,
    input  wire logic     m_axis_tready,
    // [15:0] gyro_x, [31:16] gyro_y, [47:32] gyro_z, [63:48] accel_x,
    // [79:64] accel_y, [95:80] accel_z, [114:96] temperature_centi,
    // [130:115] diag_status, [146:131] sample_count, [151:147] zero
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    output logic          m_axis_tuser      // [0] checksum_ok
);

    logic     beat_valid;
    t_in_beat beat;
    logic     advance;
    logic     out_free;
    logic     result_valid;
    t_result  result;

    // Input beat register.
    imu_bfc_in_reg u_in_reg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_advance     (advance),
        .o_beat_valid  (beat_valid),
        .o_beat        (beat)
    );

    // Frame tracking, checksum and result build.
    imu_bfc_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_beat_valid   (beat_valid),
        .i_beat         (beat),
        .i_out_free     (out_free),
        .o_advance      (advance),
        .o_result_valid (result_valid),
        .o_result       (result)
    );

    // Result register.
    imu_bfc_out_reg u_out_reg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (result_valid),
        .i_result      (result),
        .o_free        (out_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

`default_nettype wire

/* bench/imu_burst_frame_checker_tb.sv */
// ----------------------------------------------------------------------------
// IMU burst frame checker testbench
// Streams 20-byte burst frames into the checker and scoreboards every result
// beat against a cycle-free model of frame position, running sum and held
// motion words. The directed tests cover the frame after reset, trailing
// bytes and a restart mid-frame. A receiver hold-off fills the block until
// it stalls its input. A random phase then mixes well-formed frames with
// truncated frames, trailing bytes and noise. Both sides idle at random.
// ----------------------------------------------------------------------------
module imu_burst_frame_checker_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import imu_bfc_pkg::*;

    localparam int QUIET_LIMIT   = 2000;
    localparam int HOLD_CYCLES   = 150;
    localparam int RANDOM_BEATS  = 600;
    localparam int MAX_REPORTS   = 10;

    // Word slots of a frame, in byte order.
    localparam int W_DIAG  = 0;
    localparam int W_TEMP  = 7;
    localparam int W_COUNT = 8;
    localparam int N_WORDS = 9;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [7:0]             s_axis_tdata;   // [7:0] frame_byte
    logic                   s_axis_tuser;   // [0] frame_start
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // [15:0] gyro_x, [31:16] gyro_y, [47:32] gyro_z, [63:48] accel_x,
    // [79:64] accel_y, [95:80] accel_z, [114:96] temperature_centi,
    // [130:115] diag_status, [146:131] sample_count, [151:147] zero
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tuser;   // [0] checksum_ok

    imu_burst_frame_checker dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Clock: 10 ns period.
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Frame tracking state of the checker as the scoreboard sees it.
    t_pos        frame_pos;
    logic [15:0] frame_sum;
    logic [7:0]  frame_bytes [SUM_BYTES];
    logic [7:0]  chk_high;
    logic [15:0] held_motion [NUM_MOTION];

    t_result     expected_readouts [$];
    int          mismatch_count;
    int          beats_sent;
    int          quiet_cycles;

    // Stimulus controls for the sender and the receiver.
    bit          tx_idle_on;
    bit          rx_stall_on;
    int          rx_hold_len;

    // Frame under construction.
    logic [15:0] frame_words [N_WORDS];
    logic [7:0]  frame_buf [FRAME_LENGTH];

    function automatic int pick_gap(input bit enabled);
        int roll;
        roll = $urandom_range(0, 99);
        if (!enabled || roll < 55) begin
            return 0;
        end else if (roll < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [15:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h7FFF;
            3:       return 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] stored_word(input int idx);
        return {frame_bytes[idx], frame_bytes[idx + 1]};
    endfunction

    // Advance the frame tracker by one accepted byte and queue a readout when
    // the byte closes a frame.
    task automatic absorb_frame_byte(input logic [7:0] b, input logic start);
        t_result     readout;
        t_pos        pos;
        logic [15:0] chk_word;
        logic [15:0] temp_raw;
        int          temp_val;
        bit          sum_ok;
        if (start) begin
            frame_pos = '0;
            frame_sum = '0;
        end
        if (frame_pos >= FRAME_LENGTH) begin
            return;
        end
        pos       = frame_pos;
        frame_pos = pos + 1'b1;
        if (pos < SUM_BYTES) begin
            frame_bytes[pos] = b;
            frame_sum        = frame_sum + 16'(b);
        end else if (pos == CHK_HIGH_POS) begin
            chk_high = b;
        end else begin
            chk_word = {chk_high, b};
            sum_ok   = (chk_word == frame_sum);
            if (sum_ok) begin
                for (int k = 0; k < NUM_MOTION; k++) begin
                    held_motion[k] = stored_word(MOTION_BASE + 2 * k);
                end
            end
            temp_raw                  = stored_word(TEMP_BASE);
            temp_val                  = int'($signed(temp_raw)) * 5 + TEMP_OFFSET;
            readout.gyro_x            = held_motion[0];
            readout.gyro_y            = held_motion[1];
            readout.gyro_z            = held_motion[2];
            readout.accel_x           = held_motion[3];
            readout.accel_y           = held_motion[4];
            readout.accel_z           = held_motion[5];
            readout.temperature_centi = temp_val[TEMP_W-1:0];
            readout.diag_status       = stored_word(DIAG_BASE);
            readout.sample_count      = stored_word(COUNT_BASE);
            readout.checksum_ok       = sum_ok;
            expected_readouts.push_back(readout);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
                $display("%0t: %s expected %0h, got %0h", $realtime, name, exp_v, act_v);
            end
        end
    endtask

    // Result checking on the master side, then tracking on the slave side.
    // The fixed order keeps both independent of process scheduling.
    always @(posedge i_clk) begin
        t_result exp_r;
        t_result act_r;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                act_r.gyro_x            = m_axis_tdata[15:0];
                act_r.gyro_y            = m_axis_tdata[31:16];
                act_r.gyro_z            = m_axis_tdata[47:32];
                act_r.accel_x           = m_axis_tdata[63:48];
                act_r.accel_y           = m_axis_tdata[79:64];
                act_r.accel_z           = m_axis_tdata[95:80];
                act_r.temperature_centi = m_axis_tdata[114:96];
                act_r.diag_status       = m_axis_tdata[130:115];
                act_r.sample_count      = m_axis_tdata[146:131];
                act_r.checksum_ok       = m_axis_tuser;
                if (expected_readouts.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("%0t: result beat with no frame pending", $realtime);
                    end
                end else begin
                    exp_r = expected_readouts.pop_front();
                    check_field("gyro_x", exp_r.gyro_x, act_r.gyro_x);
                    check_field("gyro_y", exp_r.gyro_y, act_r.gyro_y);
                    check_field("gyro_z", exp_r.gyro_z, act_r.gyro_z);
                    check_field("accel_x", exp_r.accel_x, act_r.accel_x);
                    check_field("accel_y", exp_r.accel_y, act_r.accel_y);
                    check_field("accel_z", exp_r.accel_z, act_r.accel_z);
                    check_field("temperature_centi", exp_r.temperature_centi,
                                act_r.temperature_centi);
                    check_field("diag_status", exp_r.diag_status, act_r.diag_status);
                    check_field("sample_count", exp_r.sample_count, act_r.sample_count);
                    check_field("checksum_ok", exp_r.checksum_ok, act_r.checksum_ok);
                    check_field("pad_bits", '0, m_axis_tdata[OUT_TDATA_W-1:147]);
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                absorb_frame_byte(s_axis_tdata, s_axis_tuser);
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
    end

    // Watchdog: too long without any beat on either side.
    initial begin
        do begin
            @(posedge i_clk);
        end while (quiet_cycles < QUIET_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Receiver: random stalls, plus one long hold-off when a test asks.
    initial begin
        int stall;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_len > 0) begin
                m_axis_tready <= 1'b0;
                repeat (rx_hold_len) @(negedge i_clk);
                rx_hold_len = 0;
                m_axis_tready <= 1'b1;
            end else begin
                stall = pick_gap(rx_stall_on);
                if (stall > 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (stall) @(negedge i_clk);
                end
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Offer one byte, after an optional gap, and wait for the handshake.
    task automatic send_beat(input logic [7:0] b, input logic start);
        int gap;
        gap = pick_gap(tx_idle_on);
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= start;
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
        beats_sent++;
    endtask

    // Lay out frame_words big-endian and append the checksum word, spoiled when good_sum is clear.
    task automatic build_frame(input bit good_sum);
        logic [15:0] sum;
        sum = '0;
        for (int w = 0; w < N_WORDS; w++) begin
            frame_buf[2 * w]     = frame_words[w][15:8];
            frame_buf[2 * w + 1] = frame_words[w][7:0];
        end
        for (int i = 0; i < SUM_BYTES; i++) begin
            sum = sum + 16'(frame_buf[i]);
        end
        if (!good_sum) begin
            sum = sum + 16'($urandom_range(1, 65535));
        end
        frame_buf[CHK_HIGH_POS] = sum[15:8];
        frame_buf[CHK_LOW_POS]  = sum[7:0];
    endtask

    task automatic send_frame(input int n_bytes, input bit with_start);
        for (int i = 0; i < n_bytes; i++) begin
            send_beat(frame_buf[i], with_start && (i == 0));
        end
    endtask

    task automatic random_words();
        for (int w = 0; w < N_WORDS; w++) begin
            frame_words[w] = pick_word();
        end
    endtask

    // The first frame after reset is framed from byte 0 without a start flag.
    task automatic test_frame_after_reset();
        frame_words = '{16'hFFFF, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h0001,
                        16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF};
        build_frame(1'b1);
        send_frame(FRAME_LENGTH, 1'b0);
    endtask

    // Bytes after a completed frame are dropped until the next start.
    task automatic test_trailing_bytes();
        send_beat(8'hFF, 1'b0);
        send_beat(8'h00, 1'b0);
    endtask

    // A start in the middle of a frame discards it; the new frame fails its
    // checksum, so the motion words of the last passing frame stay held.
    task automatic test_restart_mid_frame();
        frame_words = '{16'h0000, 16'h1234, 16'hEDCB, 16'h0000, 16'h5A5A,
                        16'hA5A5, 16'h0F0F, 16'h8000, 16'h0000};
        build_frame(1'b1);
        send_frame(3, 1'b1);
        build_frame(1'b0);
        send_frame(FRAME_LENGTH, 1'b1);
    endtask

    // Hold the receiver off while frames stream in back to back, so the
    // result register fills and the input side has to stall.
    task automatic test_receiver_hold();
        tx_idle_on  = 1'b0;
        rx_hold_len = HOLD_CYCLES;
        for (int f = 0; f < 4; f++) begin
            random_words();
            build_frame(1'b1);
            send_frame(FRAME_LENGTH, 1'b1);
        end
        tx_idle_on = 1'b1;
    endtask

    // Mostly well-formed frames with random content; the rest are cut-off
    // frames, trailing bytes after a frame and loose noise bytes.
    task automatic test_random_traffic();
        int roll;
        int n;
        while (beats_sent < RANDOM_BEATS) begin
            tx_idle_on  = ($urandom_range(0, 3) != 0);
            rx_stall_on = ($urandom_range(0, 3) != 0);
            roll        = $urandom_range(0, 99);
            random_words();
            build_frame($urandom_range(0, 4) != 0);
            if (roll < 70) begin
                send_frame(FRAME_LENGTH, 1'b1);
            end else if (roll < 80) begin
                send_frame(FRAME_LENGTH, 1'b1);
                n = $urandom_range(1, 5);
                for (int i = 0; i < n; i++) begin
                    send_beat(8'($urandom), 1'b0);
                end
            end else if (roll < 90) begin
                send_frame($urandom_range(1, FRAME_LENGTH - 1), 1'b1);
            end else begin
                n = $urandom_range(1, 8);
                for (int i = 0; i < n; i++) begin
                    send_beat(8'($urandom), ($urandom_range(0, 9) == 0));
                end
            end
        end
    endtask

    // Test sequence.
    initial begin
        s_axis_tvalid    = 1'b0;
        s_axis_tdata     = '0;
        s_axis_tuser     = 1'b0;
        i_rst_n          = 1'b0;
        tx_idle_on       = 1'b1;
        rx_stall_on      = 1'b1;
        rx_hold_len      = 0;
        mismatch_count   = 0;
        beats_sent       = 0;
        quiet_cycles     = 0;
        frame_pos        = '0;
        frame_sum        = '0;
        chk_high         = '0;
        for (int i = 0; i < SUM_BYTES; i++) begin
            frame_bytes[i] = '0;
        end
        for (int k = 0; k < NUM_MOTION; k++) begin
            held_motion[k] = '0;
        end

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_frame_after_reset();
        test_trailing_bytes();
        test_restart_mid_frame();
        test_receiver_hold();
        test_random_traffic();

        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (expected_readouts.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (10) @(posedge i_clk);

        if (mismatch_count == 0 && expected_readouts.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

/* sim.f */
design/imu_bfc_pkg.sv
design/imu_bfc_in_reg.sv
design/imu_bfc_core.sv
design/imu_bfc_out_reg.sv
design/imu_burst_frame_checker.sv
bench/imu_burst_frame_checker_tb.sv
